@@ rtl/poi_pkg.sv @@
// Shared constants, types and the arctangent table of the odometry integrator.
package poi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int IN_W = 24;
    localparam int DT_W = 16;
    localparam int EPS_W = 16;
    localparam int POSE_W = 40;
    localparam int HEAD_W = 32;

    localparam int DV_W = IN_W + 1;
    localparam int SC_FRAC = 30;
    localparam int SC_W = 32;
    localparam int CZ_W = 34;
    localparam int OP_W = 34;
    localparam int ACC_W = 64;
    localparam int EX_W = 28;
    localparam int NUM_W = 60;
    localparam int DEN_W = DV_W + SC_FRAC - FRAC_BITS;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 112;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;
    localparam logic signed [OP_W-1:0] INV_TWO_PI_BA = 34'sd683565276;
    localparam logic signed [CZ_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam logic signed [ACC_W-1:0] RND_F = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] RND_SC = ACC_W'(64'sd1 <<< (SC_FRAC - 1));
    localparam logic signed [SC_W:0] ONE_SC = 33'sd1073741824;

    typedef struct packed {
        logic en;
        logic load;
        logic neg;
    } mac_ctl_t;

    function automatic logic [31:0] atan_ba(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            5'd31: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/planar_odometry_integrator.sv @@
// Planar dead-reckoning odometry: top level with sequencer, pose state and ports.
//
// One request is taken at a time; s_tready is high only while the block is idle. A request
// that moves straight or turns in place runs the CORDIC only for the heading; one that follows
// an arc also runs it for the arc angle and uses the bit-serial divider (one quotient bit per
// cycle, two divisions); the CORDIC does one iteration per cycle. All products go through
// one shared multiplier-accumulator. The result waits in an output register, so the next
// request is taken as soon as the last result has been loaded there.
// motion_epsilon is written through the cfg channel and resets to 7.
module planar_odometry_integrator #(
    parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // vel_x [23:0], vel_y [47:24], yaw_rate [71:48], delta_t [87:72]
    input  logic [poi_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pose_x_out [39:0], pose_y_out [79:40], heading_out [111:80]
    output logic [poi_pkg::M_TDATA_W-1:0]       m_tdata,
    // rotating [0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [poi_pkg::EPS_W-1:0]           cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PRE  = 4'd1;
    localparam logic [3:0] ST_ACOS = 4'd2;
    localparam logic [3:0] ST_AMUL = 4'd3;
    localparam logic [3:0] ST_DIVX = 4'd4;
    localparam logic [3:0] ST_DIVY = 4'd5;
    localparam logic [3:0] ST_HCOS = 4'd6;
    localparam logic [3:0] ST_POSE = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam int IN_W  = poi_pkg::IN_W;
    localparam int DV_W  = poi_pkg::DV_W;
    localparam int OP_W  = poi_pkg::OP_W;
    localparam int PW    = poi_pkg::POSE_W;
    localparam int FB    = poi_pkg::FRAC_BITS;
    localparam int SC_FRAC_L = poi_pkg::SC_FRAC;

    localparam logic signed [PW-1:0] POSE_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POSE_MIN = {1'b1, {(PW-1){1'b0}}};

    logic [3:0]                         state_reg;
    logic [3:0]                         state_next;
    logic [2:0]                         step_reg;
    logic [2:0]                         step_next;

    logic [poi_pkg::EPS_W-1:0]          eps_reg;
    logic signed [IN_W-1:0]             vx_reg;
    logic signed [IN_W-1:0]             vy_reg;
    logic signed [IN_W-1:0]             wz_reg;
    logic [poi_pkg::DT_W-1:0]           dt_reg;
    logic signed [DV_W-1:0]             dx_reg;
    logic signed [DV_W-1:0]             dy_reg;
    logic signed [DV_W-1:0]             ang_reg;
    logic [poi_pkg::HEAD_W-1:0]         dh_reg;
    logic signed [poi_pkg::EX_W-1:0]    ex_reg;
    logic signed [poi_pkg::EX_W-1:0]    ey_reg;
    logic signed [poi_pkg::NUM_W-1:0]   numx_reg;
    logic signed [poi_pkg::NUM_W-1:0]   numy_reg;
    logic signed [PW-1:0]               pose_x_reg;
    logic signed [PW-1:0]               pose_y_reg;
    logic [poi_pkg::HEAD_W-1:0]         heading_reg;

    logic                               m_valid_reg;
    logic signed [PW-1:0]               out_x_reg;
    logic signed [PW-1:0]               out_y_reg;
    logic [poi_pkg::HEAD_W-1:0]         out_h_reg;
    logic                               out_rot_reg;

    poi_pkg::mac_ctl_t                  mac_ctl;
    logic signed [OP_W-1:0]             mac_a;
    logic signed [OP_W-1:0]             mac_b;
    logic signed [poi_pkg::ACC_W-1:0]   mac_init;
    logic signed [poi_pkg::ACC_W-1:0]   acc;

    logic                               cor_start;
    logic [poi_pkg::HEAD_W-1:0]         cor_angle;
    logic                               cor_done;
    logic signed [poi_pkg::SC_W-1:0]    cos_val;
    logic signed [poi_pkg::SC_W-1:0]    sin_val;
    logic signed [poi_pkg::SC_W:0]      cm;

    logic                               div_start;
    logic signed [poi_pkg::NUM_W-1:0]   div_num;
    logic signed [poi_pkg::DEN_W-1:0]   den;
    logic                               div_done;
    logic signed [poi_pkg::EX_W-1:0]    quo;

    logic                               in_req;
    logic                               out_load;
    logic signed [DV_W-1:0]             acc_dv;
    logic [poi_pkg::HEAD_W-1:0]         acc_dh;
    logic signed [poi_pkg::ACC_W-SC_FRAC_L-1:0] acc_pose;
    logic [IN_W-1:0]                    wz_abs;
    logic [DV_W-1:0]                    dx_abs;
    logic [DV_W-1:0]                    dy_abs;
    logic                               rotating;
    logic                               straight;
    logic                               in_place;
    logic signed [PW:0]                 sum_x;
    logic signed [PW:0]                 sum_y;
    logic signed [PW-1:0]               sat_x;
    logic signed [PW-1:0]               sat_y;

    assign in_req    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    assign acc_dv   = acc[FB+DV_W-1:FB];
    assign acc_dh   = acc[FB+poi_pkg::HEAD_W-1:FB];
    assign acc_pose = acc[poi_pkg::ACC_W-1:SC_FRAC_L];

    assign wz_abs   = wz_reg[IN_W-1] ? -wz_reg : wz_reg;
    assign dx_abs   = dx_reg[DV_W-1] ? -dx_reg : dx_reg;
    assign dy_abs   = dy_reg[DV_W-1] ? -dy_reg : dy_reg;
    assign rotating = wz_abs >= IN_W'(eps_reg);
    assign straight = !rotating || (ang_reg == '0);
    assign in_place = (dx_abs < DV_W'(eps_reg)) && (dy_abs < DV_W'(eps_reg));

    assign cm  = poi_pkg::ONE_SC - (poi_pkg::SC_W + 1)'(cos_val);
    assign den = {ang_reg, {(poi_pkg::SC_FRAC - FB){1'b0}}};

    assign sum_x = (PW + 1)'(pose_x_reg) + (PW + 1)'(acc_pose);
    assign sum_y = (PW + 1)'(pose_y_reg) + (PW + 1)'(acc_pose);
    assign sat_x = (sum_x[PW] != sum_x[PW-1]) ? (sum_x[PW] ? POSE_MIN : POSE_MAX)
                                               : sum_x[PW-1:0];
    assign sat_y = (sum_y[PW] != sum_y[PW-1]) ? (sum_y[PW] ? POSE_MIN : POSE_MAX)
                                               : sum_y[PW-1:0];

    // Sequencer and operand selection for the shared multiplier.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + 1'b1;
        mac_ctl    = '0;
        mac_a      = '0;
        mac_b      = '0;
        mac_init   = '0;
        cor_start  = 1'b0;
        cor_angle  = heading_reg;
        div_start  = 1'b0;
        div_num    = numy_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_req)
                begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        mac_ctl  = '{en: 1'b1, load: 1'b1, neg: 1'b0};
                        mac_a    = OP_W'(vx_reg);
                        mac_b    = OP_W'(dt_reg);
                        mac_init = poi_pkg::RND_F;
                    end
                    3'd1:
                    begin
                        mac_ctl  = '{en: 1'b1, load: 1'b1, neg: 1'b0};
                        mac_a    = OP_W'(vy_reg);
                        mac_b    = OP_W'(dt_reg);
                        mac_init = poi_pkg::RND_F;
                    end
                    3'd2:
                    begin
                        mac_ctl  = '{en: 1'b1, load: 1'b1, neg: 1'b0};
                        mac_a    = OP_W'(wz_reg);
                        mac_b    = OP_W'(dt_reg);
                        mac_init = poi_pkg::RND_F;
                    end
                    3'd5:
                    begin
                        mac_ctl  = '{en: 1'b1, load: 1'b1, neg: 1'b0};
                        mac_a    = OP_W'(ang_reg);
                        mac_b    = poi_pkg::INV_TWO_PI_BA;
                        mac_init = poi_pkg::RND_F;
                    end
                    3'd7:
                    begin
                        cor_start = 1'b1;
                        step_next = '0;
                        if (straight || in_place)
                        begin
                            state_next = ST_HCOS;
                        end
                        else
                        begin
                            cor_angle  = acc_dh;
                            state_next = ST_ACOS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_ACOS:
            begin
                step_next = '0;
                if (cor_done)
                begin
                    state_next = ST_AMUL;
                end
            end
            ST_AMUL:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        mac_ctl = '{en: 1'b1, load: 1'b1, neg: 1'b0};
                        mac_a   = OP_W'(dx_reg);
                        mac_b   = OP_W'(sin_val);
                    end
                    3'd1:
                    begin
                        mac_ctl = '{en: 1'b1, load: 1'b0, neg: 1'b1};
                        mac_a   = OP_W'(dy_reg);
                        mac_b   = OP_W'(cm);
                    end
                    3'd2:
                    begin
                        mac_ctl = '{en: 1'b1, load: 1'b1, neg: 1'b0};
                        mac_a   = OP_W'(dy_reg);
                        mac_b   = OP_W'(sin_val);
                    end
                    3'd3:
                    begin
                        mac_ctl = '{en: 1'b1, load: 1'b0, neg: 1'b0};
                        mac_a   = OP_W'(dx_reg);
                        mac_b   = OP_W'(cm);
                    end
                    3'd5:
                    begin
                        div_start  = 1'b1;
                        div_num    = numx_reg;
                        state_next = ST_DIVX;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    cor_start  = 1'b1;
                    state_next = ST_HCOS;
                end
            end
            ST_HCOS:
            begin
                step_next = '0;
                if (cor_done)
                begin
                    state_next = ST_POSE;
                end
            end
            ST_POSE:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        mac_ctl  = '{en: 1'b1, load: 1'b1, neg: 1'b0};
                        mac_a    = OP_W'(cos_val);
                        mac_b    = OP_W'(ex_reg);
                        mac_init = poi_pkg::RND_SC;
                    end
                    3'd1:
                    begin
                        mac_ctl = '{en: 1'b1, load: 1'b0, neg: 1'b1};
                        mac_a   = OP_W'(sin_val);
                        mac_b   = OP_W'(ey_reg);
                    end
                    3'd2:
                    begin
                        mac_ctl  = '{en: 1'b1, load: 1'b1, neg: 1'b0};
                        mac_a    = OP_W'(sin_val);
                        mac_b    = OP_W'(ex_reg);
                        mac_init = poi_pkg::RND_SC;
                    end
                    3'd3:
                    begin
                        mac_ctl = '{en: 1'b1, load: 1'b0, neg: 1'b0};
                        mac_a   = OP_W'(cos_val);
                        mac_b   = OP_W'(ey_reg);
                    end
                    3'd5:
                    begin
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_OUT:
            begin
                step_next = '0;
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                step_next  = '0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            eps_reg     <= poi_pkg::EPS_RESET;
            pose_x_reg  <= '0;
            pose_y_reg  <= '0;
            heading_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
            if (state_reg == ST_POSE && step_reg == 3'd3)
            begin
                pose_x_reg <= sat_x;
            end
            if (state_reg == ST_POSE && step_reg == 3'd5)
            begin
                pose_y_reg  <= sat_y;
                heading_reg <= heading_reg + dh_reg;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            vx_reg <= s_tdata[IN_W-1:0];
            vy_reg <= s_tdata[2*IN_W-1:IN_W];
            wz_reg <= s_tdata[3*IN_W-1:2*IN_W];
            dt_reg <= s_tdata[3*IN_W+poi_pkg::DT_W-1:3*IN_W];
        end
        if (state_reg == ST_PRE)
        begin
            unique case (step_reg)
                3'd2: dx_reg  <= acc_dv;
                3'd3: dy_reg  <= acc_dv;
                3'd4: ang_reg <= acc_dv;
                3'd7:
                begin
                    // Straight steps keep the plain displacement; turns in place drop it.
                    if (straight)
                    begin
                        dh_reg <= '0;
                        ex_reg <= poi_pkg::EX_W'(dx_reg);
                        ey_reg <= poi_pkg::EX_W'(dy_reg);
                    end
                    else
                    begin
                        dh_reg <= acc_dh;
                        ex_reg <= '0;
                        ey_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_AMUL && step_reg == 3'd3)
        begin
            numx_reg <= acc[poi_pkg::NUM_W-1:0];
        end
        if (state_reg == ST_AMUL && step_reg == 3'd5)
        begin
            numy_reg <= acc[poi_pkg::NUM_W-1:0];
        end
        if (state_reg == ST_DIVX && div_done)
        begin
            ex_reg <= quo;
        end
        if (state_reg == ST_DIVY && div_done)
        begin
            ey_reg <= quo;
        end
        if (out_load)
        begin
            out_x_reg   <= pose_x_reg;
            out_y_reg   <= pose_y_reg;
            out_h_reg   <= heading_reg;
            out_rot_reg <= rotating;
        end
    end

    poi_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .init  (mac_init),
        .acc   (acc)
    );

    poi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    poi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den),
        .done  (div_done),
        .quo   (quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_h_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_rot_reg;

    a_div_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == ST_AMUL || state_reg == ST_DIVX))
        else $error("divider started outside the arc sequence");

    a_cor_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == ST_ACOS || state_reg == ST_HCOS))
        else $error("CORDIC finished while nobody waits for it");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> (state_reg == ST_PRE && step_reg == 3'd0))
        else $error("accepted request did not start the sequence");

    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_POSE) |=> $stable(heading_reg))
        else $error("heading changed outside the pose update");

endmodule

@@ rtl/poi_mac.sv @@
// Shared signed multiplier with a registered product and an accumulator.
module poi_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  poi_pkg::mac_ctl_t                   ctl,
    input  logic signed [poi_pkg::OP_W-1:0]     a,
    input  logic signed [poi_pkg::OP_W-1:0]     b,
    input  logic signed [poi_pkg::ACC_W-1:0]    init,
    output logic signed [poi_pkg::ACC_W-1:0]    acc
);

    logic signed [2*poi_pkg::OP_W-1:0]  prod_full;
    logic signed [poi_pkg::ACC_W-1:0]   prod_reg;
    logic signed [poi_pkg::ACC_W-1:0]   init_reg;
    poi_pkg::mac_ctl_t                  ctl_reg;
    logic signed [poi_pkg::ACC_W-1:0]   acc_reg;
    logic signed [poi_pkg::ACC_W-1:0]   acc_next;
    logic signed [poi_pkg::ACC_W-1:0]   base;

    assign prod_full = a * b;

    always_comb
    begin
        base = ctl_reg.load ? init_reg : acc_reg;
        if (!ctl_reg.en)
        begin
            acc_next = acc_reg;
        end
        else if (ctl_reg.neg)
        begin
            acc_next = base - prod_reg;
        end
        else
        begin
            acc_next = base + prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[poi_pkg::ACC_W-1:0];
        init_reg <= init;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ rtl/poi_cordic.sv @@
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module poi_cordic #(
    parameter int STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [poi_pkg::HEAD_W-1:0]         angle,
    output logic                               done,
    output logic signed [poi_pkg::SC_W-1:0]    cos_out,
    output logic signed [poi_pkg::SC_W-1:0]    sin_out
);

    localparam int CNT_W = $clog2(STEPS + 1);

    logic                               run_reg;
    logic                               done_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic                               flip_reg;
    logic signed [poi_pkg::CZ_W-1:0]    x_reg;
    logic signed [poi_pkg::CZ_W-1:0]    y_reg;
    logic signed [poi_pkg::CZ_W-1:0]    z_reg;
    logic [4:0]                         idx;
    logic signed [poi_pkg::CZ_W-1:0]    xs;
    logic signed [poi_pkg::CZ_W-1:0]    ys;
    logic signed [poi_pkg::CZ_W-1:0]    at;
    logic                               flip;
    logic [poi_pkg::HEAD_W-1:0]         ba;
    logic signed [poi_pkg::CZ_W-1:0]    x_neg;
    logic signed [poi_pkg::CZ_W-1:0]    y_neg;

    assign idx  = 5'(cnt_reg);
    assign xs   = x_reg >>> idx;
    assign ys   = y_reg >>> idx;
    assign at   = signed'({2'b00, poi_pkg::atan_ba(idx)});
    // Angles in the left half plane are turned by half a turn and negated at the end.
    assign flip = angle[31] ^ angle[30];
    assign ba   = {angle[31] ^ flip, angle[30:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flip_reg <= flip;
            x_reg    <= poi_pkg::CORDIC_INV_GAIN;
            y_reg    <= '0;
            z_reg    <= poi_pkg::CZ_W'(signed'(ba));
        end
        else if (run_reg)
        begin
            if (!z_reg[poi_pkg::CZ_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign x_neg   = -x_reg;
    assign y_neg   = -y_reg;
    assign cos_out = flip_reg ? x_neg[poi_pkg::SC_W-1:0] : x_reg[poi_pkg::SC_W-1:0];
    assign sin_out = flip_reg ? y_neg[poi_pkg::SC_W-1:0] : y_reg[poi_pkg::SC_W-1:0];
    assign done    = done_reg;

endmodule

@@ rtl/poi_div.sv @@
// Bit-serial restoring divider giving the signed quotient rounded half away from zero.
module poi_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [poi_pkg::NUM_W-1:0]   num,
    input  logic signed [poi_pkg::DEN_W-1:0]   den,
    output logic                               done,
    output logic signed [poi_pkg::EX_W-1:0]    quo
);

    localparam int CNT_W = $clog2(poi_pkg::NUM_W + 1);

    logic                           run_reg;
    logic                           done_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           neg_reg;
    logic [poi_pkg::NUM_W-1:0]      n_reg;
    logic [poi_pkg::DEN_W-1:0]      d_reg;
    logic [poi_pkg::DEN_W-1:0]      rem_reg;
    logic [poi_pkg::NUM_W-1:0]      num_abs;
    logic [poi_pkg::DEN_W-1:0]      den_abs;
    logic [poi_pkg::DEN_W:0]        trial;
    logic                           qbit;
    logic [poi_pkg::DEN_W:0]        diff;
    logic [poi_pkg::EX_W-1:0]       q_mag;

    assign num_abs = num[poi_pkg::NUM_W-1] ? -num : num;
    assign den_abs = den[poi_pkg::DEN_W-1] ? -den : den;
    assign trial   = {rem_reg, n_reg[poi_pkg::NUM_W-1]};
    assign qbit    = trial >= {1'b0, d_reg};
    assign diff    = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(poi_pkg::NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend register collects the quotient bits as it shifts out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num_abs + poi_pkg::NUM_W'(den_abs >> 1);
            d_reg   <= den_abs;
            rem_reg <= '0;
            neg_reg <= num[poi_pkg::NUM_W-1] ^ den[poi_pkg::DEN_W-1];
        end
        else if (run_reg)
        begin
            rem_reg <= qbit ? diff[poi_pkg::DEN_W-1:0] : trial[poi_pkg::DEN_W-1:0];
            n_reg   <= {n_reg[poi_pkg::NUM_W-2:0], qbit};
        end
    end

    assign q_mag = n_reg[poi_pkg::EX_W-1:0];
    assign quo   = neg_reg ? -signed'(q_mag) : signed'(q_mag);
    assign done  = done_reg;

endmodule
